// ----- rtl/conductor_fresnel_reflectance_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the conductor Fresnel reflectance block
// Each macro checks one implication on the block clock, held off during reset.
// ----------------------------------------------------------------------------
`ifndef CONDUCTOR_FRESNEL_REFLECTANCE_MACROS_SVH
`define CONDUCTOR_FRESNEL_REFLECTANCE_MACROS_SVH

// Same-cycle implication.
`define CFR_ASSERT_IMP(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("cfr assertion failed");

// Next-cycle implication.
`define CFR_ASSERT_NXT(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("cfr assertion failed");

`endif

// ----- rtl/cfr_pkg.sv -----
// ----------------------------------------------------------------------------
// Conductor Fresnel reflectance package
// Shared constants, types and the step functions of the square root and
// divider pipelines.
// ----------------------------------------------------------------------------
package cfr_pkg;

	// Reflectance of one in Q1.16.
	localparam logic [16:0] ONE_Q16 = 17'd65536;

	// Datapath widths of the root and divider pipelines.
	localparam int SQ_W  = 52;
	localparam int DIV_W = 54;

	// Step counts of the pipelined units.
	localparam int SQ1_STEPS = 26;
	localparam int SQ2_STEPS = 21;
	localparam int DIV_STEPS = 16;

	// Total register stages from input transaction to output register.
	localparam int PIPE_LAT = 4 + SQ1_STEPS + 1 + SQ2_STEPS + 3 + DIV_STEPS + 1;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_FORCE_UNIT,
		REG_ETA_RED,
		REG_ETA_GREEN,
		REG_ETA_BLUE,
		REG_KAPPA_RED,
		REG_KAPPA_GREEN,
		REG_KAPPA_BLUE
	} cfr_reg_t;

	// Outcome of a reflectance ratio.
	typedef enum logic [1:0] {
		DIV_NORM,
		DIV_ONE,
		DIV_TWO
	} cfr_div_code_t;

	// Complex index of one channel.
	typedef struct packed {
		logic [15:0] eta;
		logic [15:0] kappa;
	} cfr_idx_t;

	// Values carried alongside the square roots.
	typedef struct packed {
		logic        [16:0] c;
		logic signed [25:0] zr;
		logic signed [24:0] ar;
		logic        [24:0] ai;
	} cfr_car_t;

	// Square root state: remainder and partial root.
	typedef struct packed {
		logic [SQ_W-1:0] x;
		logic [SQ_W-1:0] r;
	} cfr_sq_t;

	// Divider state.
	typedef struct packed {
		cfr_div_code_t    code;
		logic [16:0]      q;
		logic [DIV_W-1:0] r;
		logic [DIV_W-1:0] den;
	} cfr_dv_t;

	// Trial bit of root step i out of n steps.
	function automatic logic [SQ_W-1:0] sq_bit(input int n, input int i);
		logic [SQ_W-1:0] b;
		b = SQ_W'(1) << (2 * (n - 1 - i));
		return b;
	endfunction

	// One step of the digit-by-digit square root.
	function automatic cfr_sq_t sqrt_step(input cfr_sq_t s, input logic [SQ_W-1:0] b);
		logic [SQ_W-1:0] t;
		cfr_sq_t o;
		t = s.r + b;
		if (s.x >= t) begin
			o.x = s.x - t;
			o.r = (s.r >> 1) + b;
		end else begin
			o.x = s.x;
			o.r = s.r >> 1;
		end
		return o;
	endfunction

	// Divider setup: special cases and the integer quotient bit.
	function automatic cfr_dv_t div_init(input logic [DIV_W-1:0] num,
			input logic [DIV_W-1:0] den);
		cfr_dv_t o;
		o.code = DIV_NORM;
		o.q    = '0;
		o.r    = num;
		o.den  = den;
		if (den == '0) begin
			o.code = DIV_ONE;
		end else if ({1'b0, num} >= {den, 1'b0}) begin
			o.code = DIV_TWO;
		end else if (num >= den) begin
			o.q = 17'd1;
			o.r = num - den;
		end
		return o;
	endfunction

	// One restoring division step producing one fraction bit.
	function automatic cfr_dv_t div_step(input cfr_dv_t s);
		logic [DIV_W-1:0] t;
		cfr_dv_t o;
		o   = s;
		t   = s.r << 1;
		o.q = {s.q[15:0], 1'b0};
		if (t >= s.den) begin
			o.r    = t - s.den;
			o.q[0] = 1'b1;
		end else begin
			o.r = t;
		end
		return o;
	endfunction

	// Ratio value in Q.16 after the special cases.
	function automatic logic [17:0] div_value(input cfr_dv_t s);
		logic [17:0] v;
		case (s.code)
			DIV_ONE: v = 18'd65536;
			DIV_TWO: v = 18'd131072;
			default: v = {1'b0, s.q};
		endcase
		return v;
	endfunction

endpackage

// ----- rtl/cfr_channel.sv -----
// ----------------------------------------------------------------------------
// Conductor Fresnel reflectance, one color channel
// Pipelined datapath from clamped cosine to saturated reflectance.
// ----------------------------------------------------------------------------
module cfr_channel
	import cfr_pkg::*;
(
	input  logic        clk,
	input  logic        adv,
	input  logic [16:0] c_in,
	input  cfr_idx_t    idx,
	output logic [16:0] refl
);

	// Stage 1: index and cosine products.
	logic [31:0] ee_s1, kk_s1, ek_s1;
	logic [32:0] cc_s1;
	logic [16:0] c_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			ee_s1 <= idx.eta * idx.eta;
			kk_s1 <= idx.kappa * idx.kappa;
			ek_s1 <= idx.eta * idx.kappa;
			cc_s1 <= 33'(c_in * c_in);
			c_s1  <= c_in;
		end
	end

	// Stage 2: n squared minus sine squared, scaled to Q.16 with truncation.
	logic signed [33:0] n2r24, n2_adj;
	logic        [24:0] sin2;
	logic signed [34:0] zd, zd_adj;
	logic signed [25:0] zr_s2;
	logic signed [24:0] n2r_s2;
	logic        [24:0] zi_s2;
	logic        [16:0] c_s2;

	always_comb begin
		n2r24  = $signed({2'b00, ee_s1}) - $signed({2'b00, kk_s1});
		sin2   = 25'((33'h1_0000_0000 - cc_s1) >> 8);
		zd     = $signed({n2r24[33], n2r24}) - $signed({10'd0, sin2});
		zd_adj = zd + (zd[34] ? 35'sd255 : 35'sd0);
		n2_adj = n2r24 + (n2r24[33] ? 34'sd255 : 34'sd0);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			zr_s2  <= 26'(zd_adj >>> 8);
			n2r_s2 <= 25'(n2_adj >>> 8);
			zi_s2  <= ek_s1[31:7];
			c_s2   <= c_s1;
		end
	end

	// Stage 3: squares for the modulus and the n squared times cosine products.
	logic        [25:0] zr_abs;
	logic        [51:0] zr2_s3;
	logic        [49:0] zi2_s3;
	logic signed [42:0] prodr_s3;
	logic        [41:0] prodi_s3;
	logic signed [25:0] zr_s3;
	logic        [16:0] c_s3;

	assign zr_abs = zr_s2[25] ? 26'(-zr_s2) : 26'(zr_s2);

	always_ff @(posedge clk) begin
		if (adv) begin
			zr2_s3   <= zr_abs * zr_abs;
			zi2_s3   <= zi_s2 * zi_s2;
			prodr_s3 <= n2r_s2 * $signed({1'b0, c_s2});
			prodi_s3 <= zi_s2 * c_s2;
			zr_s3    <= zr_s2;
			c_s3     <= c_s2;
		end
	end

	// Stage 4: modulus radicand and the scaled products.
	logic signed [42:0] prodr_adj;
	cfr_sq_t  sq_s4;
	cfr_car_t car_s4;

	assign prodr_adj = prodr_s3 + (prodr_s3[42] ? 43'sd65535 : 43'sd0);

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_s4.x   <= zr2_s3 + SQ_W'(zi2_s3);
			sq_s4.r   <= '0;
			car_s4.c  <= c_s3;
			car_s4.zr <= zr_s3;
			car_s4.ar <= 25'(prodr_adj >>> 16);
			car_s4.ai <= prodi_s3[40:16];
		end
	end

	// Modulus root, one digit per stage.
	cfr_sq_t  msq_s [SQ1_STEPS];
	cfr_car_t mcar_s [SQ1_STEPS];

	always_ff @(posedge clk) begin
		if (adv) begin
			msq_s[0]  <= sqrt_step(sq_s4, sq_bit(SQ1_STEPS, 0));
			mcar_s[0] <= car_s4;
			for (int i = 1; i < SQ1_STEPS; i++) begin
				msq_s[i]  <= sqrt_step(msq_s[i-1], sq_bit(SQ1_STEPS, i));
				mcar_s[i] <= mcar_s[i-1];
			end
		end
	end

	// Stage after the modulus: radicands of the real and imaginary gamma parts.
	logic        [25:0] m_val;
	logic signed [27:0] mp, mm;
	cfr_sq_t  gr_init_s5, gi_init_s5;
	cfr_car_t car_s5;

	always_comb begin
		m_val = msq_s[SQ1_STEPS-1].r[25:0];
		mp    = $signed({2'b00, m_val}) + 28'(mcar_s[SQ1_STEPS-1].zr);
		mm    = $signed({2'b00, m_val}) - 28'(mcar_s[SQ1_STEPS-1].zr);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			gr_init_s5.x <= SQ_W'({mp[26:0], 15'd0});
			gr_init_s5.r <= '0;
			gi_init_s5.x <= SQ_W'({mm[26:0], 15'd0});
			gi_init_s5.r <= '0;
			car_s5       <= mcar_s[SQ1_STEPS-1];
		end
	end

	// Gamma roots, both parts side by side, one digit per stage.
	cfr_sq_t  grq_s [SQ2_STEPS];
	cfr_sq_t  giq_s [SQ2_STEPS];
	cfr_car_t gcar_s [SQ2_STEPS];

	always_ff @(posedge clk) begin
		if (adv) begin
			grq_s[0]  <= sqrt_step(gr_init_s5, sq_bit(SQ2_STEPS, 0));
			giq_s[0]  <= sqrt_step(gi_init_s5, sq_bit(SQ2_STEPS, 0));
			gcar_s[0] <= car_s5;
			for (int i = 1; i < SQ2_STEPS; i++) begin
				grq_s[i]  <= sqrt_step(grq_s[i-1], sq_bit(SQ2_STEPS, i));
				giq_s[i]  <= sqrt_step(giq_s[i-1], sq_bit(SQ2_STEPS, i));
				gcar_s[i] <= gcar_s[i-1];
			end
		end
	end

	// Squares of the numerator and denominator terms.
	logic        [20:0] gr, gi;
	cfr_car_t           gcar;
	logic signed [21:0] dsm;
	logic        [21:0] dsm_a, dsp;
	logic signed [25:0] arm, arp, aim;
	logic        [25:0] arm_a, arp_a, aim_a, aip;
	logic [43:0] dsm2_s6, dsp2_s6;
	logic [41:0] gi2_s6;
	logic [51:0] arm2_s6, arp2_s6, aim2_s6, aip2_s6;

	always_comb begin
		gr    = grq_s[SQ2_STEPS-1].r[20:0];
		gi    = giq_s[SQ2_STEPS-1].r[20:0];
		gcar  = gcar_s[SQ2_STEPS-1];
		dsm   = $signed({1'b0, gcar.c}) - $signed({1'b0, gr});
		dsm_a = dsm[21] ? 22'(-dsm) : 22'(dsm);
		dsp   = 22'(gcar.c) + 22'(gr);
		arm   = 26'(gcar.ar) - $signed({5'd0, gr});
		arp   = 26'(gcar.ar) + $signed({5'd0, gr});
		aim   = $signed({1'b0, gcar.ai}) - $signed({5'd0, gi});
		aip   = 26'(gcar.ai) + 26'(gi);
		arm_a = arm[25] ? 26'(-arm) : 26'(arm);
		arp_a = arp[25] ? 26'(-arp) : 26'(arp);
		aim_a = aim[25] ? 26'(-aim) : 26'(aim);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dsm2_s6 <= dsm_a * dsm_a;
			dsp2_s6 <= dsp * dsp;
			gi2_s6  <= gi * gi;
			arm2_s6 <= arm_a * arm_a;
			arp2_s6 <= arp_a * arp_a;
			aim2_s6 <= aim_a * aim_a;
			aip2_s6 <= aip * aip;
		end
	end

	// Squared magnitudes of both ratios.
	logic [DIV_W-1:0] nums_s7, dens_s7, nump_s7, denp_s7;

	always_ff @(posedge clk) begin
		if (adv) begin
			nums_s7 <= DIV_W'(dsm2_s6) + DIV_W'(gi2_s6);
			dens_s7 <= DIV_W'(dsp2_s6) + DIV_W'(gi2_s6);
			nump_s7 <= DIV_W'(arm2_s6) + DIV_W'(aim2_s6);
			denp_s7 <= DIV_W'(arp2_s6) + DIV_W'(aip2_s6);
		end
	end

	// Divider setup for both ratios.
	cfr_dv_t dvs_s8, dvp_s8;

	always_ff @(posedge clk) begin
		if (adv) begin
			dvs_s8 <= div_init(nums_s7, dens_s7);
			dvp_s8 <= div_init(nump_s7, denp_s7);
		end
	end

	// Fraction bits, one per stage.
	cfr_dv_t dvs_s [DIV_STEPS];
	cfr_dv_t dvp_s [DIV_STEPS];

	always_ff @(posedge clk) begin
		if (adv) begin
			dvs_s[0] <= div_step(dvs_s8);
			dvp_s[0] <= div_step(dvp_s8);
			for (int i = 1; i < DIV_STEPS; i++) begin
				dvs_s[i] <= div_step(dvs_s[i-1]);
				dvp_s[i] <= div_step(dvp_s[i-1]);
			end
		end
	end

	// Mean of both ratios, saturated to one.
	logic [18:0] rsum;
	logic [17:0] rmean;
	logic [16:0] refl_q;

	always_comb begin
		rsum  = 19'(div_value(dvs_s[DIV_STEPS-1])) + 19'(div_value(dvp_s[DIV_STEPS-1]));
		rmean = rsum[18:1];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			refl_q <= (rmean > 18'(ONE_Q16)) ? ONE_Q16 : rmean[16:0];
		end
	end

	assign refl = refl_q;

endmodule

// ----- rtl/conductor_fresnel_reflectance.sv -----
// ----------------------------------------------------------------------------
// Conductor Fresnel reflectance
// Unpolarized reflectance of three color channels of a conductor for one
// incidence cosine per transaction.
// ----------------------------------------------------------------------------
// Usage:
// The input stream carries one signed Q2.16 cosine per transaction; the
// output stream returns three Q1.16 reflectances, 65536 meaning one.
// The complex index of each channel and the force flag sit in APB registers
// at byte addresses 0 (force), 4..12 (eta red, green, blue) and
// 16..24 (kappa red, green, blue); write them only while the block is idle.
// From an input transaction to the earliest output transaction of its
// result an item passes four setup stages, a 26-stage modulus root, one
// radicand stage, a 21-stage gamma root, two product stages, a 17-stage ratio
// divider and the output register.
// Throughput is one transaction per cycle unless the receiver stalls; the pipeline advances as a whole.
// When the receiver stalls with a result waiting, every stage holds and the
// input side drops tready; bubbles inside the pipeline are not squeezed out.
// Reset empties the pipeline and loads eta 1.0, kappa 0 and force off.
// ----------------------------------------------------------------------------
`include "conductor_fresnel_reflectance_macros.svh"

module conductor_fresnel_reflectance
	import cfr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Input stream.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // [17:0] cos_incidence
	// Output stream.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata   // [16:0] refl_red, [33:17] refl_green, [50:34] refl_blue
);

	// Configuration registers.
	logic        force_q;
	logic [15:0] eta_red_q, eta_green_q, eta_blue_q;
	logic [15:0] kappa_red_q, kappa_green_q, kappa_blue_q;
	logic        cfg_wr;
	cfr_reg_t    reg_sel;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_sel = cfr_reg_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			force_q       <= 1'b0;
			eta_red_q     <= 16'd4096;
			eta_green_q   <= 16'd4096;
			eta_blue_q    <= 16'd4096;
			kappa_red_q   <= 16'd0;
			kappa_green_q <= 16'd0;
			kappa_blue_q  <= 16'd0;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				REG_FORCE_UNIT:  force_q       <= pwdata[0];
				REG_ETA_RED:     eta_red_q     <= pwdata[15:0];
				REG_ETA_GREEN:   eta_green_q   <= pwdata[15:0];
				REG_ETA_BLUE:    eta_blue_q    <= pwdata[15:0];
				REG_KAPPA_RED:   kappa_red_q   <= pwdata[15:0];
				REG_KAPPA_GREEN: kappa_green_q <= pwdata[15:0];
				REG_KAPPA_BLUE:  kappa_blue_q  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Register read back.
	always_comb begin
		unique case (reg_sel)
			REG_FORCE_UNIT:  prdata = {31'd0, force_q};
			REG_ETA_RED:     prdata = {16'd0, eta_red_q};
			REG_ETA_GREEN:   prdata = {16'd0, eta_green_q};
			REG_ETA_BLUE:    prdata = {16'd0, eta_blue_q};
			REG_KAPPA_RED:   prdata = {16'd0, kappa_red_q};
			REG_KAPPA_GREEN: prdata = {16'd0, kappa_green_q};
			REG_KAPPA_BLUE:  prdata = {16'd0, kappa_blue_q};
			default:         prdata = 32'd0;
		endcase
	end

	// Pipeline advance: the whole pipeline moves unless a result is stuck.
	logic [PIPE_LAT-1:0] vld_s;
	logic [PIPE_LAT-1:0] spec_s;
	logic                adv;

	assign adv           = !vld_s[PIPE_LAT-1] || m_axis_tready;
	assign s_axis_tready = adv;
	assign m_axis_tvalid = vld_s[PIPE_LAT-1];

	// Cosine magnitude clamped to one.
	logic [17:0] cos_v, mag;
	logic [16:0] c_in;
	logic        spec_in;

	always_comb begin
		cos_v   = s_axis_tdata[17:0];
		mag     = cos_v[17] ? 18'(-cos_v) : cos_v;
		c_in    = (mag > 18'(ONE_Q16)) ? ONE_Q16 : mag[16:0];
		spec_in = force_q || (c_in == 17'd0);
	end

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[PIPE_LAT-2:0], s_axis_tvalid};
		end
	end

	// Full-reflectance marks for forced and grazing items.
	always_ff @(posedge clk) begin
		if (adv) begin
			spec_s <= {spec_s[PIPE_LAT-2:0], spec_in};
		end
	end

	// Channel datapaths.
	cfr_idx_t    idx_red, idx_green, idx_blue;
	logic [16:0] ch_red, ch_green, ch_blue;
	logic [16:0] refl_red, refl_green, refl_blue;

	assign idx_red   = '{eta: eta_red_q,   kappa: kappa_red_q};
	assign idx_green = '{eta: eta_green_q, kappa: kappa_green_q};
	assign idx_blue  = '{eta: eta_blue_q,  kappa: kappa_blue_q};

	cfr_channel u_red (
		.clk  (clk),
		.adv  (adv),
		.c_in (c_in),
		.idx  (idx_red),
		.refl (ch_red)
	);

	cfr_channel u_green (
		.clk  (clk),
		.adv  (adv),
		.c_in (c_in),
		.idx  (idx_green),
		.refl (ch_green)
	);

	cfr_channel u_blue (
		.clk  (clk),
		.adv  (adv),
		.c_in (c_in),
		.idx  (idx_blue),
		.refl (ch_blue)
	);

	// Output payload with full reflectance for marked items.
	always_comb begin
		refl_red     = spec_s[PIPE_LAT-1] ? ONE_Q16 : ch_red;
		refl_green   = spec_s[PIPE_LAT-1] ? ONE_Q16 : ch_green;
		refl_blue    = spec_s[PIPE_LAT-1] ? ONE_Q16 : ch_blue;
		m_axis_tdata = {5'd0, refl_blue, refl_green, refl_red};
	end

	// A stuck result freezes the input side.
	`CFR_ASSERT_IMP(a_stall_holds_input, m_axis_tvalid && !m_axis_tready, !s_axis_tready)
	// An accepted transaction occupies the first stage.
	`CFR_ASSERT_NXT(a_accept_enters, s_axis_tvalid && s_axis_tready, vld_s[0])
	// Reflectances never exceed one.
	`CFR_ASSERT_IMP(a_refl_range, m_axis_tvalid, refl_red <= ONE_Q16 && refl_green <= ONE_Q16 && refl_blue <= ONE_Q16)

endmodule
